// File: design/csmc_pkg.sv
// ----------------------------------------------------------------------------
// csmc_pkg
// Shared types, mode codes and Q16 coefficient table for the colour space
// matrix converter.
// ----------------------------------------------------------------------------
package csmc_pkg;

    // component and arithmetic widths
    localparam int COMP_W   = 8;
    localparam int OPND_W   = COMP_W + 1;
    localparam int COEF_W   = 19;
    localparam int PROD_W   = COEF_W + OPND_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int FRAC_W   = 16;
    localparam int INT_W    = SUM_W - FRAC_W;
    localparam int VAL_W    = INT_W + 1;
    localparam int MODE_W   = 3;
    localparam int N_CH     = 3;

    // mode register codes
    typedef enum logic [MODE_W-1:0] {
        MODE_RGB_YUV   = 3'd0,
        MODE_YUV_RGB   = 3'd1,
        MODE_RGB_YIQ   = 3'd2,
        MODE_YIQ_RGB   = 3'd3,
        MODE_RGB_YCBCR = 3'd4,
        MODE_YCBCR_RGB = 3'd5
    } mode_t;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // input beat
    typedef struct packed {
        logic [COMP_W-1:0] comp_a;
        logic [COMP_W-1:0] comp_b;
        logic [COMP_W-1:0] comp_c;
    } pixel_in_t;

    // result beat
    typedef struct packed {
        logic [COMP_W-1:0] out_a;
        logic [COMP_W-1:0] out_b;
        logic [COMP_W-1:0] out_c;
    } pixel_out_t;

    // control travelling alongside a beat
    typedef struct packed {
        logic valid;
        logic off_pre;
        logic off_post;
    } stage_ctrl_t;

    // chroma offset in Q16 added before truncation, or as an integer after it
    localparam logic signed [SUM_W-1:0] CHROMA_PRE =
        SUM_W'(128) <<< FRAC_W;
    localparam logic signed [VAL_W-1:0] CHROMA_POST = VAL_W'(128);
    localparam logic signed [VAL_W-1:0] SAT_MAX     = VAL_W'(255);

    // coefficient table [mode][row][col], Q16; spare codes give identity
    localparam coef_t COEF_TABLE [8][N_CH][N_CH] = '{
        '{ '{ 19'sd19595,  19'sd38470,  19'sd7471  },
           '{ -19'sd9642,  -19'sd18931, 19'sd28574 },
           '{ 19'sd40305,  -19'sd33750, -19'sd6554 } },
        '{ '{ 19'sd65536,  19'sd0,      19'sd74700  },
           '{ 19'sd65536,  -19'sd25864, -19'sd38050 },
           '{ 19'sd65536,  19'sd133176, 19'sd0      } },
        '{ '{ 19'sd19595,  19'sd38470,  19'sd7471   },
           '{ 19'sd39053,  -19'sd17996, -19'sd21057 },
           '{ 19'sd13861,  -19'sd34256, 19'sd20395  } },
        '{ '{ 19'sd65536,  19'sd62652,  19'sd40567  },
           '{ 19'sd65536,  -19'sd17826, -19'sd42402 },
           '{ 19'sd65536,  -19'sd72483, 19'sd111608 } },
        '{ '{ 19'sd19595,  19'sd38470,  19'sd7471   },
           '{ -19'sd11058, -19'sd21710, 19'sd32768  },
           '{ 19'sd32768,  -19'sd27439, -19'sd5329  } },
        '{ '{ 19'sd65536,  19'sd0,      19'sd91881  },
           '{ 19'sd65536,  -19'sd22553, -19'sd46802 },
           '{ 19'sd65536,  19'sd116130, 19'sd0      } },
        '{ '{ 19'sd65536,  19'sd0,      19'sd0      },
           '{ 19'sd0,      19'sd65536,  19'sd0      },
           '{ 19'sd0,      19'sd0,      19'sd65536  } },
        '{ '{ 19'sd65536,  19'sd0,      19'sd0      },
           '{ 19'sd0,      19'sd65536,  19'sd0      },
           '{ 19'sd0,      19'sd0,      19'sd65536  } }
    };

    // inverse conversions take chroma relative to 128
    function automatic logic mode_is_inverse(logic [MODE_W-1:0] mode);
        logic inv;
        case (mode)
            MODE_YUV_RGB, MODE_YIQ_RGB, MODE_YCBCR_RGB: inv = 1'b1;
            default:                                    inv = 1'b0;
        endcase
        return inv;
    endfunction

endpackage

// File: design/color_space_matrix_convert_top.sv
// ----------------------------------------------------------------------------
// color_space_matrix_convert_top
// Converts one pixel per beat between RGB and YUV, YIQ or YCbCr through a
// fixed 3x3 Q16 matrix chosen by the mode register.
// ----------------------------------------------------------------------------
// Throughput: one pixel every cycle; busy is always low.
// The accepted beat passes through the input, product and result registers
// before the result strobe is raised.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset clears the pipeline strobes and sets the mode to RGB to YUV.
// ----------------------------------------------------------------------------
module color_space_matrix_convert_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  csmc_pkg::pixel_in_t           pixel_in,
    input  logic                          cfg_we,
    input  logic [csmc_pkg::MODE_W-1:0]   cfg_wdata,
    output logic                          result_valid,
    output csmc_pkg::pixel_out_t          pixel_out
);
    import csmc_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic              accept;
    stage_ctrl_t       in_ctrl;
    stage_ctrl_t       prod_ctrl;
    logic [MODE_W-1:0] in_mode;
    opnd_t             opnd [N_CH];
    prod_t             prod [N_CH][N_CH];

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RGB_YUV;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // a new beat is taken every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    csmc_input_stage u_input_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .mode     (mode_reg),
        .pixel_in (pixel_in),
        .ctrl     (in_ctrl),
        .mode_out (in_mode),
        .opnd     (opnd)
    );

    csmc_product_stage u_product_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (in_ctrl),
        .mode     (in_mode),
        .opnd     (opnd),
        .ctrl_out (prod_ctrl),
        .prod     (prod)
    );

    csmc_output_stage u_output_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (prod_ctrl),
        .prod         (prod),
        .result_valid (result_valid),
        .pixel_out    (pixel_out)
    );

endmodule

// File: design/csmc_input_stage.sv
// ----------------------------------------------------------------------------
// csmc_input_stage
// Registers the accepted beat as signed operands, removing the chroma bias
// for inverse modes, and the offset flags for the chroma rows.
// ----------------------------------------------------------------------------
module csmc_input_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [csmc_pkg::MODE_W-1:0]   mode,
    input  csmc_pkg::pixel_in_t           pixel_in,
    output csmc_pkg::stage_ctrl_t         ctrl,
    output logic [csmc_pkg::MODE_W-1:0]   mode_out,
    output csmc_pkg::opnd_t               opnd [csmc_pkg::N_CH]
);
    import csmc_pkg::*;

    stage_ctrl_t             ctrl_reg, ctrl_next;
    logic [MODE_W-1:0]       mode_reg;
    opnd_t                   opnd_reg  [N_CH];
    opnd_t                   opnd_next [N_CH];
    logic                    inverse;

    // operand preparation
    always_comb
    begin
        inverse      = mode_is_inverse(mode);
        opnd_next[0] = $signed({1'b0, pixel_in.comp_a});
        opnd_next[1] = $signed({1'b0, pixel_in.comp_b});
        opnd_next[2] = $signed({1'b0, pixel_in.comp_c});
        if (inverse)
        begin
            opnd_next[1] = opnd_next[1] - OPND_W'(128);
            opnd_next[2] = opnd_next[2] - OPND_W'(128);
        end
        ctrl_next.valid    = accept;
        ctrl_next.off_pre  = (mode == MODE_RGB_YCBCR);
        ctrl_next.off_post = (mode == MODE_RGB_YUV) || (mode == MODE_RGB_YIQ);
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            opnd_reg <= opnd_next;
        end
    end

    assign ctrl     = ctrl_reg;
    assign mode_out = mode_reg;
    assign opnd     = opnd_reg;

endmodule

// File: design/csmc_product_stage.sv
// ----------------------------------------------------------------------------
// csmc_product_stage
// Nine coefficient by operand multipliers, one per matrix entry, with the
// products registered.
// ----------------------------------------------------------------------------
module csmc_product_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  csmc_pkg::stage_ctrl_t         ctrl_in,
    input  logic [csmc_pkg::MODE_W-1:0]   mode,
    input  csmc_pkg::opnd_t               opnd [csmc_pkg::N_CH],
    output csmc_pkg::stage_ctrl_t         ctrl_out,
    output csmc_pkg::prod_t               prod [csmc_pkg::N_CH][csmc_pkg::N_CH]
);
    import csmc_pkg::*;

    stage_ctrl_t ctrl_reg;
    prod_t       prod_reg  [N_CH][N_CH];
    prod_t       prod_next [N_CH][N_CH];

    // matrix entry products
    always_comb
    begin
        for (int r = 0; r < N_CH; r++)
        begin
            for (int c = 0; c < N_CH; c++)
            begin
                prod_next[r][c] = PROD_W'(COEF_TABLE[mode][r][c]) * PROD_W'(opnd[c]);
            end
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (ctrl_in.valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign prod     = prod_reg;

endmodule

// File: design/csmc_output_stage.sv
// ----------------------------------------------------------------------------
// csmc_output_stage
// Row sums, chroma offset, truncation toward zero and saturation to 0..255,
// into the result register.
// ----------------------------------------------------------------------------
module csmc_output_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  csmc_pkg::stage_ctrl_t         ctrl,
    input  csmc_pkg::prod_t               prod [csmc_pkg::N_CH][csmc_pkg::N_CH],
    output logic                          result_valid,
    output csmc_pkg::pixel_out_t          pixel_out
);
    import csmc_pkg::*;

    logic                        valid_reg;
    pixel_out_t                  pixel_reg, pixel_next;
    logic signed [SUM_W-1:0]     sum    [N_CH];
    logic signed [INT_W-1:0]     whole  [N_CH];
    logic signed [VAL_W-1:0]     val    [N_CH];
    logic [COMP_W-1:0]           sat    [N_CH];

    // per row: sum, offset, truncate toward zero, saturate
    always_comb
    begin
        for (int r = 0; r < N_CH; r++)
        begin
            sum[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2]);
            if (r != 0 && ctrl.off_pre)
            begin
                sum[r] = sum[r] + CHROMA_PRE;
            end
            whole[r] = sum[r][SUM_W-1:FRAC_W];
            if (sum[r][SUM_W-1] && (sum[r][FRAC_W-1:0] != '0))
            begin
                whole[r] = whole[r] + INT_W'(1);
            end
            val[r] = VAL_W'(whole[r]);
            if (r != 0 && ctrl.off_post)
            begin
                val[r] = val[r] + CHROMA_POST;
            end
            if (val[r][VAL_W-1])
            begin
                sat[r] = '0;
            end
            else if (val[r] > SAT_MAX)
            begin
                sat[r] = '1;
            end
            else
            begin
                sat[r] = val[r][COMP_W-1:0];
            end
        end
        pixel_next.out_a = sat[0];
        pixel_next.out_b = sat[1];
        pixel_next.out_c = sat[2];
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctrl.valid;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign result_valid = valid_reg;
    assign pixel_out    = pixel_reg;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the colour space matrix converter one pixel at a time. Each pixel
// without a literal result is converted again here with the Q16 weights,
// truncation toward zero and saturation to 0..255, and the result beat is
// compared field by field. Runs a table of corner pixels per mode, then random
// pixels over every mode code with the sender idling at different rates.
// ----------------------------------------------------------------------------
module tb;

    import csmc_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          SETTLE_CYC   = 8;
    localparam int          N_SEGMENTS   = 16;
    localparam int          SEG_PIXELS   = 53;
    localparam int          N_DIRECTED   = 24;
    localparam int          FRAC         = 16;
    localparam longint      OFFSET_128   = 128;
    localparam logic [2:0]  MODE_SPARE_6 = 3'd6;
    localparam logic [2:0]  MODE_SPARE_7 = 3'd7;

    // Q16 weights per mode; inverse modes only use the chroma columns
    localparam longint WEIGHTS [6][3][3] = '{
        '{ '{ 19595,  38470,   7471 }, '{ -9642, -18931,  28574 },
           '{ 40305, -33750,  -6554 } },
        '{ '{ 0,      0,      74700 }, '{ 0,     -25864, -38050 },
           '{ 0,      133176, 0     } },
        '{ '{ 19595,  38470,   7471 }, '{ 39053, -17996, -21057 },
           '{ 13861, -34256,  20395 } },
        '{ '{ 0,      62652,  40567 }, '{ 0,     -17826, -42402 },
           '{ 0,     -72483, 111608 } },
        '{ '{ 19595,  38470,   7471 }, '{ -11058, -21710, 32768 },
           '{ 32768, -27439,  -5329 } },
        '{ '{ 0,      0,      91881 }, '{ 0,     -22553, -46802 },
           '{ 0,      116130, 0     } }
    };

    // one row of the corner table; known rows carry a literal result
    typedef struct packed {
        logic [2:0] mode;
        pixel_in_t  px;
        logic       known;
        pixel_out_t want;
    } corner_row_t;

    localparam corner_row_t CORNERS [N_DIRECTED] = '{
        '{ MODE_RGB_YUV,   '{8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd128, 8'd128} },
        '{ MODE_RGB_YUV,   '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd128, 8'd128} },
        '{ MODE_RGB_YUV,   '{8'd255, 8'd0,   8'd0  }, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_RGB_YUV,   '{8'd0,   8'd0,   8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_RGB_YUV,   '{8'd0,   8'd255, 8'd0  }, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_YUV_RGB,   '{8'd0,   8'd128, 8'd128}, 1'b1, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_YUV_RGB,   '{8'd255, 8'd128, 8'd128}, 1'b1, '{8'd255, 8'd255, 8'd255} },
        '{ MODE_YUV_RGB,   '{8'd0,   8'd0,   8'd0  }, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_YUV_RGB,   '{8'd255, 8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_YUV_RGB,   '{8'd128, 8'd0,   8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_RGB_YIQ,   '{8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd128, 8'd128} },
        '{ MODE_RGB_YIQ,   '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd128, 8'd128} },
        '{ MODE_RGB_YIQ,   '{8'd255, 8'd0,   8'd0  }, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_YIQ_RGB,   '{8'd0,   8'd128, 8'd128}, 1'b1, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_YIQ_RGB,   '{8'd255, 8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_YIQ_RGB,   '{8'd0,   8'd0,   8'd0  }, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_RGB_YCBCR, '{8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd128, 8'd128} },
        '{ MODE_RGB_YCBCR, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd128, 8'd128} },
        '{ MODE_RGB_YCBCR, '{8'd0,   8'd0,   8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_RGB_YCBCR, '{8'd255, 8'd0,   8'd0  }, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_YCBCR_RGB, '{8'd255, 8'd128, 8'd128}, 1'b1, '{8'd255, 8'd255, 8'd255} },
        '{ MODE_YCBCR_RGB, '{8'd0,   8'd255, 8'd0  }, 1'b0, '{8'd0,   8'd0,   8'd0  } },
        '{ MODE_SPARE_6,   '{8'h12,  8'hAB,  8'hFF }, 1'b1, '{8'h12,  8'hAB,  8'hFF } },
        '{ MODE_SPARE_7,   '{8'h00,  8'h80,  8'h7F }, 1'b1, '{8'h00,  8'h80,  8'h7F } }
    };

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    pixel_in_t           pixel_in;
    logic                cfg_we;
    logic [MODE_W-1:0]   cfg_wdata;
    logic                result_valid;
    pixel_out_t          pixel_out;

    // literal result travelling with the beat being driven
    logic                lit_known;
    pixel_out_t          lit_want;

    pixel_out_t          pending_pixels [$];
    logic [2:0]          model_mode;
    logic [2:0]          drv_mode;
    int                  bad_pixels;
    int                  cycle_count;

    color_space_matrix_convert_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel_in     (pixel_in),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .pixel_out    (pixel_out)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // drop the 16 fractional bits on the magnitude
    function automatic longint trunc_q16(input longint s);
        if (s >= 0)
            return s >>> FRAC;
        return -((-s) >>> FRAC);
    endfunction

    function automatic logic [7:0] clamp_u8(input longint v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // converted pixel for the given mode
    function automatic pixel_out_t convert_pixel(input logic [2:0] mode,
                                                 input pixel_in_t px);
        longint     x [3];
        longint     acc;
        longint     v;
        logic [7:0] res [3];
        int         m;
        x[0] = longint'(px.comp_a);
        x[1] = longint'(px.comp_b);
        x[2] = longint'(px.comp_c);
        m = int'(mode);
        case (mode)
            MODE_RGB_YUV, MODE_RGB_YIQ, MODE_RGB_YCBCR:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    acc = WEIGHTS[m][k][0] * x[0] + WEIGHTS[m][k][1] * x[1]
                        + WEIGHTS[m][k][2] * x[2];
                    if (k == 0)
                        v = trunc_q16(acc);
                    else if (mode == MODE_RGB_YCBCR)
                        v = trunc_q16(acc + (OFFSET_128 <<< FRAC));
                    else
                        v = trunc_q16(acc) + OFFSET_128;
                    res[k] = clamp_u8(v);
                end
            end
            MODE_YUV_RGB, MODE_YIQ_RGB, MODE_YCBCR_RGB:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    acc = (x[0] <<< FRAC) + WEIGHTS[m][k][1] * (x[1] - OFFSET_128)
                        + WEIGHTS[m][k][2] * (x[2] - OFFSET_128);
                    res[k] = clamp_u8(trunc_q16(acc));
                end
            end
            // spare codes pass the pixel through
            default:
            begin
                for (int k = 0; k < 3; k++)
                    res[k] = x[k][7:0];
            end
        endcase
        return '{out_a: res[0], out_b: res[1], out_c: res[2]};
    endfunction

    // random pixel, weighted toward extremes, greys and neutral chroma
    function automatic pixel_in_t random_pixel();
        pixel_in_t px;
        int        kind;
        kind = $urandom_range(0, 9);
        px.comp_a = 8'($urandom_range(0, 255));
        px.comp_b = 8'($urandom_range(0, 255));
        px.comp_c = 8'($urandom_range(0, 255));
        case (kind)
            6:
            begin
                px.comp_a = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                px.comp_b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                px.comp_c = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            7:
            begin
                px.comp_b = 8'($urandom_range(120, 136));
                px.comp_c = 8'($urandom_range(120, 136));
            end
            8:
            begin
                px.comp_b = px.comp_a;
                px.comp_c = px.comp_a;
            end
            9:  px.comp_a = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: ;
        endcase
        return px;
    endfunction

    // drive one beat at a falling edge, hold it until accepted
    task automatic send_pixel(input pixel_in_t px, input logic known,
                              input pixel_out_t want, input int idle_pct);
        while (int'($urandom_range(0, 99)) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        pixel_in  <= px;
        lit_known <= known;
        lit_want  <= want;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        @(negedge clk);
    endtask

    // stop sending and wait for every pending pixel plus the pipeline tail
    task automatic drain_pixels();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // mode write, only with the converter idle
    task automatic write_mode(input logic [2:0] mode);
        drain_pixels();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
        drv_mode = mode;
    endtask

    // result check and expectation capture at each rising edge
    always @(posedge clk)
    begin : monitor
        pixel_out_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, pixel_out);
                    bad_pixels++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pixel_out.out_a !== want.out_a)
                    begin
                        $display("%0t: out_a expected %0d actual %0d",
                                 $time, want.out_a, pixel_out.out_a);
                        bad_pixels++;
                    end
                    if (pixel_out.out_b !== want.out_b)
                    begin
                        $display("%0t: out_b expected %0d actual %0d",
                                 $time, want.out_b, pixel_out.out_b);
                        bad_pixels++;
                    end
                    if (pixel_out.out_c !== want.out_c)
                    begin
                        $display("%0t: out_c expected %0d actual %0d",
                                 $time, want.out_c, pixel_out.out_c);
                        bad_pixels++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (lit_known)
                    pending_pixels.push_back(lit_want);
                else
                    pending_pixels.push_back(convert_pixel(model_mode, pixel_in));
            end
            if (cfg_we)
                model_mode <= cfg_wdata;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int          idle_pct;
        logic [2:0]  seg_mode;
        corner_row_t row;
        rst_n       = 1'b0;
        start       = 1'b0;
        pixel_in    = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        lit_known   = 1'b0;
        lit_want    = '0;
        model_mode  = MODE_RGB_YUV;
        drv_mode    = MODE_RGB_YUV;
        bad_pixels  = 0;
        cycle_count = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corner table, mode changes only between rows of different mode
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = CORNERS[i];
            if (row.mode != drv_mode)
                write_mode(row.mode);
            send_pixel(row.px, row.known, row.want, 0);
        end

        // random segments: every mode code, sender idle 0, 58 or 16 percent
        for (int s = 0; s < N_SEGMENTS; s++)
        begin
            seg_mode = 3'((s * 3) % 8);
            case (s % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 58;
                default: idle_pct = 16;
            endcase
            write_mode(seg_mode);
            for (int n = 0; n < SEG_PIXELS; n++)
                send_pixel(random_pixel(), 1'b0, '0, idle_pct);
        end

        drain_pixels();
        if (bad_pixels == 0 && pending_pixels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
